>>> src/mlsc_pkg.sv
// Package for the MPLS label stack classifier.
// Holds the shared codes, sizes and the verdict structure; depends on nothing.
`timescale 1ns / 1ps

package mlsc_pkg;

	localparam int MAX_PACKET_BYTES = 16384;
	localparam int OFFSET_W = 14;
	localparam int LABEL_W = 20;
	localparam int OFFSET_LIMIT_INT = (MAX_PACKET_BYTES - 1 < 16383) ?
		(MAX_PACKET_BYTES - 1) : 16383;
	localparam logic [OFFSET_W-1:0] OFFSET_LIMIT = OFFSET_LIMIT_INT[OFFSET_W-1:0];

	localparam logic [LABEL_W-1:0] RESERVED_BELOW = 20'd15;
	localparam logic [OFFSET_W:0] PW_WORD_BYTES = 15'd4;

	localparam logic [3:0] NIB_IPV4 = 4'h4;
	localparam logic [3:0] NIB_IPV6 = 4'h6;
	localparam logic [3:0] NIB_PW = 4'h0;

	localparam logic [LABEL_W-1:0] LBL_IPV4_NULL = 20'd0;
	localparam logic [LABEL_W-1:0] LBL_ALERT = 20'd1;
	localparam logic [LABEL_W-1:0] LBL_IPV6_NULL = 20'd2;
	localparam logic [LABEL_W-1:0] LBL_IMPL_NULL = 20'd3;

	typedef enum logic [1:0] {
		PROTO_V4 = 2'd0,
		PROTO_V6 = 2'd1,
		PROTO_ETH = 2'd2,
		PROTO_NONE = 2'd3
	} proto_t;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0,
		ERR_SMALL = 3'd1,
		ERR_ALERT = 3'd2,
		ERR_NULL = 3'd3,
		ERR_RESERVED = 3'd4,
		ERR_UNKNOWN = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		PH_STACK = 3'b001,
		PH_AWAIT = 3'b010,
		PH_SKIP = 3'b100
	} phase_t;

	typedef struct packed {
		logic emit;
		proto_t proto;
		err_t err;
		logic [OFFSET_W-1:0] offset;
		logic [LABEL_W-1:0] label;
	} verdict_t;

endpackage

>>> src/mpls_label_stack_classifier.sv
// MPLS label stack classifier, top level: input register, parser, result register.
// Depends on mlsc_pkg, mlsc_parser and mlsc_out_stage.
// Verdicts are formed from the input register and held in the result register.
// Throughput: one byte per cycle; the byte in the input register moves on whenever the
// result register is empty or being emptied in that cycle.
// Reset: arst_n clears the handshake valids and all parser state to the start of a packet.
`timescale 1ns / 1ps

module mpls_label_stack_classifier import mlsc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] data_byte,
	input logic end_of_packet,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] next_protocol,
	output logic [2:0] error_code,
	output logic [OFFSET_W-1:0] payload_offset,
	output logic [LABEL_W-1:0] bottom_label
);

	// Input register. It holds one byte; the byte leaves when the parser advances,
	// and a new byte can enter in the same cycle.
	logic valid_s1;
	logic [7:0] byte_s1;
	logic eop_s1;
	logic advance;
	verdict_t verdict;

	// The parser advances only when the result register has room, so a byte that
	// produces a verdict never overwrites one still waiting to be taken.
	assign advance = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eop_s1 <= end_of_packet;
		end
	end

	// Parser state advances once per byte and returns to the label stack at
	// every packet end.
	mlsc_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.byte_s1(byte_s1),
		.eop_s1(eop_s1),
		.verdict(verdict)
	);

	// At most one verdict per packet is loaded into the result register.
	mlsc_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.verdict(verdict),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.next_protocol(next_protocol),
		.error_code(error_code),
		.payload_offset(payload_offset),
		.bottom_label(bottom_label)
	);

endmodule

>>> src/mlsc_parser.sv
// Label stack parser: per-packet state and the verdict for one byte.
// Depends on mlsc_pkg.
`timescale 1ns / 1ps

module mlsc_parser import mlsc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic [7:0] byte_s1,
	input logic eop_s1,
	output verdict_t verdict
);

	logic [23:0] entry_shift_q;
	logic [1:0] byte_in_entry_q;
	logic [OFFSET_W-1:0] byte_offset_q;
	phase_t phase_q;
	logic [LABEL_W-1:0] held_label_q;

	logic [23:0] entry_shift_d;
	logic [1:0] byte_in_entry_d;
	logic [OFFSET_W-1:0] offset_next;
	phase_t phase_d;
	logic [LABEL_W-1:0] held_label_d;
	logic [LABEL_W-1:0] lab;
	logic [OFFSET_W:0] pw_sum;
	logic [OFFSET_W-1:0] pw_offset;

	assign offset_next = (byte_offset_q >= OFFSET_LIMIT) ? OFFSET_LIMIT : byte_offset_q + 1'b1;
	assign pw_sum = {1'b0, byte_offset_q} + PW_WORD_BYTES;
	assign pw_offset = (pw_sum > {1'b0, OFFSET_LIMIT}) ? OFFSET_LIMIT : pw_sum[OFFSET_W-1:0];
	assign lab = entry_shift_q[23:4];

	always_comb begin
		entry_shift_d = entry_shift_q;
		byte_in_entry_d = byte_in_entry_q;
		phase_d = phase_q;
		held_label_d = held_label_q;
		verdict = '{emit: 1'b0, proto: PROTO_NONE, err: ERR_SMALL,
			offset: offset_next, label: '0};
		case (phase_q)
			PH_STACK: begin
				if (byte_in_entry_q != 2'd3) begin
					entry_shift_d = {entry_shift_q[15:0], byte_s1};
					byte_in_entry_d = byte_in_entry_q + 2'd1;
					verdict.emit = eop_s1;
				end else begin
					entry_shift_d = '0;
					byte_in_entry_d = 2'd0;
					if (!entry_shift_q[0]) begin
						verdict.emit = eop_s1;
					end else begin
						verdict.emit = 1'b1;
						verdict.label = lab;
						phase_d = PH_SKIP;
						if (lab == LBL_IPV4_NULL) begin
							verdict.proto = PROTO_V4;
							verdict.err = ERR_OK;
						end else if (lab == LBL_ALERT) begin
							verdict.err = ERR_ALERT;
						end else if (lab == LBL_IPV6_NULL) begin
							verdict.proto = PROTO_V6;
							verdict.err = ERR_OK;
						end else if (lab == LBL_IMPL_NULL) begin
							verdict.err = ERR_NULL;
						end else if (lab < RESERVED_BELOW) begin
							verdict.err = ERR_RESERVED;
						end else if (!eop_s1) begin
							// The verdict waits for the first payload nibble.
							verdict.emit = 1'b0;
							held_label_d = lab;
							phase_d = PH_AWAIT;
						end
					end
				end
			end
			PH_AWAIT: begin
				verdict.emit = 1'b1;
				verdict.label = held_label_q;
				verdict.offset = byte_offset_q;
				verdict.err = ERR_OK;
				phase_d = PH_SKIP;
				case (byte_s1[7:4])
					NIB_IPV4: verdict.proto = PROTO_V4;
					NIB_IPV6: verdict.proto = PROTO_V6;
					NIB_PW: begin
						verdict.proto = PROTO_ETH;
						verdict.offset = pw_offset;
					end
					default: verdict.err = ERR_UNKNOWN;
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_shift_q <= '0;
			byte_in_entry_q <= 2'd0;
			byte_offset_q <= '0;
			phase_q <= PH_STACK;
			held_label_q <= '0;
		end else if (advance) begin
			if (eop_s1) begin
				entry_shift_q <= '0;
				byte_in_entry_q <= 2'd0;
				byte_offset_q <= '0;
				phase_q <= PH_STACK;
				held_label_q <= '0;
			end else begin
				entry_shift_q <= entry_shift_d;
				byte_in_entry_q <= byte_in_entry_d;
				byte_offset_q <= offset_next;
				phase_q <= phase_d;
				held_label_q <= held_label_d;
			end
		end
	end

	a_err_no_proto: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.emit && verdict.err != ERR_OK |-> verdict.proto == PROTO_NONE)
		else $error("error verdict carries a protocol");
	a_await_label: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_AWAIT |-> held_label_q >= RESERVED_BELOW)
		else $error("awaiting payload with a special label");
	a_eop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eop_s1 |=> phase_q == PH_STACK && byte_in_entry_q == 2'd0
			&& byte_offset_q == '0)
		else $error("packet end did not clear parser state");
	a_pw_only_await: assert property (@(posedge clk) disable iff (!arst_n)
		verdict.emit && verdict.proto == PROTO_ETH |-> phase_q == PH_AWAIT)
		else $error("pseudowire verdict outside payload peek");

endmodule

>>> src/mlsc_out_stage.sv
// Result register of the classifier, with its valid/ready handshake.
// Depends on mlsc_pkg.
`timescale 1ns / 1ps

module mlsc_out_stage import mlsc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input verdict_t verdict,
	input logic out_ready,
	output logic out_valid,
	output logic [1:0] next_protocol,
	output logic [2:0] error_code,
	output logic [OFFSET_W-1:0] payload_offset,
	output logic [LABEL_W-1:0] bottom_label
);

	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && verdict.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && verdict.emit) begin
			next_protocol <= verdict.proto;
			error_code <= verdict.err;
			payload_offset <= verdict.offset;
			bottom_label <= verdict.label;
		end
	end

	assign out_valid = out_valid_q;

endmodule
